// File: rtl/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// Types and constants shared by the channel binding table and its channels.
// ----------------------------------------------------------------------------
package tcb_pkg;

  parameter int unsigned TcbTableEntries = 16;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_LIFETIME = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAXIMUM_LIFETIME = 1'b1;

  localparam logic [31:0] DefaultLifetimeRst = 32'd600;
  localparam logic [31:0] MaximumLifetimeRst = 32'd3600;

  localparam logic [15:0] ChanLow        = 16'h4000;
  localparam logic [15:0] ChanHigh       = 16'h7ffe;
  localparam logic [1:0]  ChanDataTag    = 2'b01;
  localparam logic [16:0] ClientHdrBytes = 17'd4;
  localparam logic [47:0] BytesMax       = 48'hffff_ffff_ffff;

  typedef enum logic [1:0] {
    OP_BIND        = 2'd0,
    OP_CLIENT_DATA = 2'd1,
    OP_PEER_DATA   = 2'd2,
    OP_REFRESH     = 2'd3
  } tcb_op_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_REQUEST = 2'd1,
    STATUS_TABLE_FULL  = 2'd2,
    STATUS_DROPPED     = 2'd3
  } tcb_status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] channel_word;
    logic [31:0] peer_address;
    logic [15:0] peer_port_in;
    logic [15:0] payload_length;
    logic [15:0] datagram_size;
    logic [31:0] requested_lifetime;
  } tcb_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        forward;
    logic [15:0] channel_out;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [15:0] relay_length;
    logic [31:0] granted_lifetime;
    logic [47:0] byte_total;
  } tcb_rsp_t;

  // one binding as stored in the table memory
  typedef struct packed {
    logic [15:0] channel;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
  } tcb_entry_t;

  localparam int unsigned EntryW = $bits(tcb_entry_t);

endpackage

// File: rtl/tcb_in_if.sv
// ----------------------------------------------------------------------------
// tcb_in_if
// Request channel of the channel binding table: valid, ready and one request.
// ----------------------------------------------------------------------------
interface tcb_in_if
  import tcb_pkg::*;
();
  logic     valid;
  logic     ready;
  tcb_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tcb_out_if.sv
// ----------------------------------------------------------------------------
// tcb_out_if
// Result channel of the channel binding table: valid, ready and one result.
// ----------------------------------------------------------------------------
interface tcb_out_if
  import tcb_pkg::*;
();
  logic     valid;
  logic     ready;
  tcb_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tcb_ram.sv
// ----------------------------------------------------------------------------
// tcb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/turn_channel_binding_table.sv
// ----------------------------------------------------------------------------
// turn_channel_binding_table
// Channel bindings of one relay allocation: bind, client channel data,
// peer datagram and refresh/release, one result per request.
// ----------------------------------------------------------------------------
// Requests arrive on in_i and results leave on out_o, both valid/ready; a
// transfer happens when valid and ready are high at a clock edge. The
// lifetime bounds are written through cfg_we_i/cfg_idx_i/cfg_data_i.
// The bindings sit in one memory; bind, client data and peer requests scan
// all TableEntries entries, one memory read per cycle, and their result is
// written to the output register after the scan. Refresh skips the scan
// and goes straight to the FINISH state. The next request is taken in the
// cycle after a result is written to the output register. If the receiver
// stalls, the result waits in the output register; a following request is
// still taken and scanned, and stops before its result only while the
// register is full and its result is not being taken.
// Reset empties the table at once (valid bits in flops), zeroes the byte
// total and loads the lifetime bounds with 600 and 3600 seconds.
// ----------------------------------------------------------------------------
module turn_channel_binding_table
  import tcb_pkg::*;
#(
  parameter int unsigned TableEntries = TcbTableEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tcb_in_if.sink              in_i,
  tcb_out_if.source           out_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_e;

  state_e state_q;

  // lifetime bounds and byte total
  logic [31:0] default_lifetime_q;
  logic [31:0] maximum_lifetime_q;
  logic [47:0] bytes_q, bytes_d;
  logic [TableEntries-1:0] valid_q;

  // scan control
  logic [IdxW-1:0] ptr_q;
  logic            issuing_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  // scan results
  logic            chan_hit_q;
  logic            peer_hit_q;
  logic            conflict_q;
  logic            free_found_q;
  logic [IdxW-1:0] free_idx_q;
  logic [31:0]     hit_addr_q;
  logic [15:0]     hit_port_q;
  logic [15:0]     hit_chan_q;

  tcb_req_t req_q;
  tcb_rsp_t rsp_q, rsp_d;
  logic     out_valid_q;

  // memory
  logic [EntryW-1:0] ram_rdata;
  tcb_entry_t        rd_entry;
  tcb_entry_t        wr_entry;
  logic              ram_we;

  logic in_xfer;
  logic finish_go;
  logic release_go;
  logic ch_match;
  logic pr_match;

  assign in_i.ready  = (state_q == IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = rsp_q;
  assign finish_go   = (state_q == FINISH) && (!out_valid_q || out_o.ready);

  assign rd_entry = tcb_entry_t'(ram_rdata);
  assign ch_match = (rd_entry.channel == req_q.channel_word);
  assign pr_match = (rd_entry.peer_address == req_q.peer_address) &&
                    (rd_entry.peer_port == req_q.peer_port_in);

  assign wr_entry.channel      = req_q.channel_word;
  assign wr_entry.peer_address = req_q.peer_address;
  assign wr_entry.peer_port    = req_q.peer_port_in;

  tcb_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // result and side effects of the finished request
  always_comb begin
    logic        range_bad;
    logic        client_ok;
    logic [48:0] bytes_sum;
    logic [31:0] grant;

    rsp_d      = '0;
    bytes_d    = bytes_q;
    ram_we     = 1'b0;
    release_go = 1'b0;
    range_bad  = (req_q.channel_word < ChanLow) || (req_q.channel_word > ChanHigh) ||
                 (req_q.peer_address == '0) || (req_q.peer_port_in == '0);
    client_ok  = (req_q.datagram_size >= 16'd4) &&
                 (req_q.channel_word[15:14] == ChanDataTag) && chan_hit_q &&
                 (({1'b0, req_q.payload_length} + ClientHdrBytes) <=
                  {1'b0, req_q.datagram_size});
    bytes_sum  = {1'b0, bytes_q} + {33'd0, req_q.payload_length};
    grant      = (req_q.requested_lifetime < maximum_lifetime_q) ?
                 req_q.requested_lifetime : maximum_lifetime_q;
    if (grant < default_lifetime_q) begin
      grant = default_lifetime_q;
    end

    case (req_q.op)
      OP_BIND: begin
        if (range_bad || conflict_q) begin
          rsp_d.status = STATUS_BAD_REQUEST;
        end else if (chan_hit_q) begin
          rsp_d.status = STATUS_OK;
        end else if (!free_found_q) begin
          rsp_d.status = STATUS_TABLE_FULL;
        end else begin
          rsp_d.status = STATUS_OK;
          ram_we       = finish_go;
        end
      end
      OP_CLIENT_DATA: begin
        if (client_ok) begin
          rsp_d.forward      = 1'b1;
          rsp_d.dest_address = hit_addr_q;
          rsp_d.dest_port    = hit_port_q;
          rsp_d.relay_length = req_q.payload_length;
          bytes_d            = bytes_sum[48] ? BytesMax : bytes_sum[47:0];
        end else begin
          rsp_d.status = STATUS_DROPPED;
        end
      end
      OP_PEER_DATA: begin
        if (peer_hit_q) begin
          rsp_d.forward      = 1'b1;
          rsp_d.channel_out  = hit_chan_q;
          rsp_d.relay_length = req_q.payload_length;
        end else begin
          rsp_d.status = STATUS_DROPPED;
        end
      end
      OP_REFRESH: begin
        if (req_q.requested_lifetime == '0) begin
          rsp_d.byte_total = bytes_q;
          bytes_d          = '0;
          release_go       = 1'b1;
        end else begin
          rsp_d.granted_lifetime = grant;
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= IDLE;
      default_lifetime_q <= DefaultLifetimeRst;
      maximum_lifetime_q <= MaximumLifetimeRst;
      bytes_q            <= '0;
      valid_q            <= '0;
      ptr_q              <= '0;
      issuing_q          <= 1'b0;
      rd_vld_q           <= 1'b0;
      rd_idx_q           <= '0;
      chan_hit_q         <= 1'b0;
      peer_hit_q         <= 1'b0;
      conflict_q         <= 1'b0;
      free_found_q       <= 1'b0;
      free_idx_q         <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEFAULT_LIFETIME: default_lifetime_q <= cfg_data_i;
          CFG_MAXIMUM_LIFETIME: maximum_lifetime_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && !finish_go) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        IDLE: begin
          if (in_xfer) begin
            ptr_q        <= '0;
            rd_vld_q     <= 1'b0;
            chan_hit_q   <= 1'b0;
            peer_hit_q   <= 1'b0;
            conflict_q   <= 1'b0;
            free_found_q <= 1'b0;
            if (in_i.data.op == OP_REFRESH) begin
              issuing_q <= 1'b0;
              state_q   <= FINISH;
            end else begin
              issuing_q <= 1'b1;
              state_q   <= SCAN;
            end
          end
        end
        SCAN: begin
          // one read issued and one entry checked per cycle
          rd_vld_q <= issuing_q;
          rd_idx_q <= ptr_q;
          if (issuing_q) begin
            if (ptr_q == LastIdx) begin
              issuing_q <= 1'b0;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
          if (rd_vld_q) begin
            if (valid_q[rd_idx_q]) begin
              if (ch_match) begin
                chan_hit_q <= 1'b1;
                if (!pr_match) begin
                  conflict_q <= 1'b1;
                end
              end
              if (pr_match) begin
                peer_hit_q <= 1'b1;
                if (!ch_match) begin
                  conflict_q <= 1'b1;
                end
              end
            end else if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= rd_idx_q;
            end
            if (rd_idx_q == LastIdx) begin
              state_q <= FINISH;
            end
          end
        end
        FINISH: begin
          if (finish_go) begin
            out_valid_q <= 1'b1;
            bytes_q     <= bytes_d;
            if (ram_we) begin
              valid_q[free_idx_q] <= 1'b1;
            end
            if (release_go) begin
              valid_q <= '0;
            end
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_i.data;
    end
    if (finish_go) begin
      rsp_q <= rsp_d;
    end
    if (state_q == SCAN && rd_vld_q && valid_q[rd_idx_q]) begin
      if (ch_match) begin
        hit_addr_q <= rd_entry.peer_address;
        hit_port_q <= rd_entry.peer_port;
      end
      if (pr_match) begin
        hit_chan_q <= rd_entry.channel;
      end
    end
  end

endmodule
